// ===== hw/rtl/lcdd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdd_pkg
// Types, command codes and lookup tables shared by the LCD digit driver.
// ----------------------------------------------------------------------------
package lcdd_pkg;

  localparam int unsigned FrameTicksDefault = 5;
  localparam int unsigned FrameCntW         = 6;
  localparam int unsigned PeriodW           = 11;
  localparam int unsigned ElapsedW          = 16;

  // Command codes
  localparam logic [7:0] CmdBlinkStart = 8'd34;
  localparam logic [7:0] CmdBlinkStop  = 8'd35;
  localparam logic [7:0] CmdLightA     = 8'd36;
  localparam logic [7:0] CmdLightB     = 8'd37;
  localparam logic [7:0] CmdLightC     = 8'd38;
  localparam logic [7:0] CmdClear      = 8'd39;

  // Character codes with special handling
  localparam logic [7:0] CodeBlank    = 8'd10;
  localparam logic [7:0] CodeAltBlank = 8'd11;
  localparam logic [7:0] CodeSpace    = 8'd32;
  localparam logic [7:0] CodePoint    = 8'd46;

  localparam logic [PeriodW-1:0] BlinkPeriodReset = 11'd20;

  typedef struct packed {
    logic [7:0]           char_code;
    logic                 point_on;
    logic                 blink_on;
    logic [PeriodW-1:0]   blink_period;
    logic [ElapsedW-1:0]  blink_elapsed;
    logic [FrameCntW-1:0] frame_elapsed;
    logic                 phase;
    logic [7:0]           pin_latch;
  } lcdd_state_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] mask;  // bit 0 = a ... bit 6 = g
  } glyph_t;

  function automatic glyph_t glyph_lookup(logic [7:0] code);
    glyph_t g;
    g.hit = 1'b1;
    unique case (code)
      8'd48:   g.mask = 7'h3F;
      8'd49:   g.mask = 7'h06;
      8'd50:   g.mask = 7'h5B;
      8'd51:   g.mask = 7'h4F;
      8'd52:   g.mask = 7'h66;
      8'd53:   g.mask = 7'h6D;
      8'd54:   g.mask = 7'h7D;
      8'd55:   g.mask = 7'h07;
      8'd56:   g.mask = 7'h7F;
      8'd57:   g.mask = 7'h6F;
      8'd45:   g.mask = 7'h40;
      8'd20:   g.mask = 7'h63;
      8'd65:   g.mask = 7'h77;
      8'd98:   g.mask = 7'h7C;
      8'd99:   g.mask = 7'h58;
      8'd67:   g.mask = 7'h39;
      8'd100:  g.mask = 7'h5E;
      8'd69:   g.mask = 7'h79;
      8'd70:   g.mask = 7'h71;
      8'd72:   g.mask = 7'h76;
      8'd73:   g.mask = 7'h30;
      8'd76:   g.mask = 7'h38;
      8'd79:   g.mask = 7'h3F;
      8'd80:   g.mask = 7'h73;
      8'd83:   g.mask = 7'h6D;
      8'd85:   g.mask = 7'h3E;
      8'd117:  g.mask = 7'h1C;
      8'd27:   g.mask = 7'h01;
      8'd28:   g.mask = 7'h02;
      8'd29:   g.mask = 7'h04;
      8'd30:   g.mask = 7'h08;
      8'd31:   g.mask = 7'h10;
      8'd40:   g.mask = 7'h20;
      8'd33:   g.mask = 7'h40;
      default: begin
        g.hit  = 1'b0;
        g.mask = 7'h00;
      end
    endcase
    return g;
  endfunction

  function automatic logic [PeriodW-1:0] blink_step(logic [2:0] idx);
    logic [PeriodW-1:0] p;
    unique case (idx)
      3'd0:    p = 11'd100;
      3'd1:    p = 11'd200;
      3'd2:    p = 11'd300;
      3'd3:    p = 11'd400;
      3'd4:    p = 11'd500;
      3'd5:    p = 11'd1000;
      3'd6:    p = 11'd1500;
      default: p = 11'd2000;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/lcdd_step.sv =====
// ----------------------------------------------------------------------------
// lcdd_step
// Next-state logic for one command or millisecond tick: command decode,
// blink and frame timers, and the pin redraw on a frame boundary.
// ----------------------------------------------------------------------------
module lcdd_step #(
  parameter int unsigned FRAME_TICKS = lcdd_pkg::FrameTicksDefault
) (
  input  lcdd_pkg::lcdd_state_t cur_i,
  input  logic                  op_i,
  input  logic [7:0]            cmd_byte_i,
  input  logic [7:0]            arg_byte_i,
  output lcdd_pkg::lcdd_state_t nxt_o
);

  localparam logic [lcdd_pkg::FrameCntW-1:0] FrameTicksW =
    lcdd_pkg::FrameCntW'(FRAME_TICKS);
  localparam logic [lcdd_pkg::FrameCntW-1:0] FrameMax = '1;

  lcdd_pkg::glyph_t glyph;

  assign glyph = lcdd_pkg::glyph_lookup(cur_i.char_code);

  always_comb begin
    lcdd_pkg::lcdd_state_t s;
    logic                  drawable;
    logic [7:0]            mask;
    s        = cur_i;
    drawable = 1'b0;
    mask     = '0;
    if (op_i) begin
      if (s.blink_elapsed != '1) begin
        s.blink_elapsed = s.blink_elapsed + 1'b1;
      end
      if (s.blink_on &&
          s.blink_elapsed >= {{(lcdd_pkg::ElapsedW - lcdd_pkg::PeriodW){1'b0}},
                              s.blink_period}) begin
        s.blink_elapsed = '0;
        s.point_on      = ~s.point_on;
      end
      if (s.frame_elapsed != FrameMax) begin
        s.frame_elapsed = s.frame_elapsed + 1'b1;
      end
      if (s.frame_elapsed >= FrameTicksW) begin
        s.frame_elapsed = '0;
        s.phase         = ~s.phase;
        // Redraw; unknown codes hold the segment pins
        priority if (s.char_code == lcdd_pkg::CodeSpace) begin
          drawable = 1'b1;
          mask     = 8'h00;
        end else if (s.char_code == lcdd_pkg::CodePoint) begin
          drawable   = 1'b1;
          s.point_on = 1'b1;
          mask       = 8'h80;
        end else if (s.char_code == lcdd_pkg::CodeBlank) begin
          drawable = 1'b1;
          mask     = {s.point_on, 7'h00};
        end else begin
          drawable = glyph.hit;
          mask     = {s.point_on, glyph.mask};
        end
        if (drawable) begin
          s.pin_latch = s.phase ? ~mask : mask;
        end
      end
    end else begin
      priority if (cmd_byte_i == lcdd_pkg::CmdBlinkStart) begin
        if (s.char_code == lcdd_pkg::CodeAltBlank) begin
          s.char_code = lcdd_pkg::CodeBlank;
        end
        s.blink_on = 1'b1;
        if (arg_byte_i[7:3] == 5'd0) begin
          s.blink_period = lcdd_pkg::blink_step(arg_byte_i[2:0]);
        end
      end else if (cmd_byte_i == lcdd_pkg::CmdBlinkStop) begin
        s.blink_on = 1'b0;
        if (arg_byte_i == 8'd0) begin
          s.point_on = 1'b0;
        end else if (arg_byte_i == 8'd1) begin
          s.point_on = 1'b1;
        end
      end else if (cmd_byte_i == lcdd_pkg::CmdLightA ||
                   cmd_byte_i == lcdd_pkg::CmdLightB ||
                   cmd_byte_i == lcdd_pkg::CmdLightC) begin
        // backlight control is not wired here
        s = cur_i;
      end else if (cmd_byte_i == lcdd_pkg::CmdClear) begin
        s.blink_on  = 1'b0;
        s.point_on  = 1'b0;
        s.char_code = lcdd_pkg::CodeBlank;
      end else begin
        s.char_code = cmd_byte_i;
        if (!s.blink_on) begin
          s.point_on = (arg_byte_i != 8'd0);
        end
      end
    end
    nxt_o = s;
  end

endmodule

// ===== hw/rtl/lcd_digit_command_driver_core.sv =====
// ----------------------------------------------------------------------------
// lcd_digit_command_driver_core
// One-digit seven-segment LCD driver with an AC backplane, fed by host
// commands and millisecond ticks; one pin snapshot returned per transfer.
// ----------------------------------------------------------------------------
// Latency: the pin snapshot for a transfer is registered and valid in the cycle after it.
// Throughput: one command or tick per cycle while the output is not stalled; the state update and redraw
// are a single combinational pass between the state and result registers.
// Reset: blank character, point and blink off, blink period 20 ticks,
// timers cleared, state phase and pin latch low, no result pending.
module lcd_digit_command_driver_core #(
  parameter int unsigned FRAME_TICKS = lcdd_pkg::FrameTicksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] arg_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       seg_a_o,
  output logic       seg_b_o,
  output logic       seg_c_o,
  output logic       seg_d_o,
  output logic       seg_e_o,
  output logic       seg_f_o,
  output logic       seg_g_o,
  output logic       seg_point_o,
  output logic       backplane_o
);

  lcdd_pkg::lcdd_state_t state_q, state_d;
  logic                  in_xfer;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            pins_q;
  logic                  bp_q;

  // Take a new item whenever the result slot is empty or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  lcdd_step #(
    .FRAME_TICKS(FRAME_TICKS)
  ) u_step (
    .cur_i      (state_q),
    .op_i       (op_i),
    .cmd_byte_i (cmd_byte_i),
    .arg_byte_i (arg_byte_i),
    .nxt_o      (state_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.char_code     <= lcdd_pkg::CodeBlank;
      state_q.point_on      <= 1'b0;
      state_q.blink_on      <= 1'b0;
      state_q.blink_period  <= lcdd_pkg::BlinkPeriodReset;
      state_q.blink_elapsed <= '0;
      state_q.frame_elapsed <= '0;
      state_q.phase         <= 1'b0;
      state_q.pin_latch     <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pins_q <= state_d.pin_latch;
      bp_q   <= state_d.phase;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_a_o     = pins_q[0];
  assign seg_b_o     = pins_q[1];
  assign seg_c_o     = pins_q[2];
  assign seg_d_o     = pins_q[3];
  assign seg_e_o     = pins_q[4];
  assign seg_f_o     = pins_q[5];
  assign seg_g_o     = pins_q[6];
  assign seg_point_o = pins_q[7];
  assign backplane_o = bp_q;

endmodule

// ===== tb/sv/lcd_digit_command_driver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_digit_command_driver_core_tb
// Drives host commands and millisecond ticks into the LCD digit driver and
// checks every pin snapshot against an in-bench model of the character,
// decimal point, blink and backplane behavior, under random idling and
// output back-pressure.
// ----------------------------------------------------------------------------
module lcd_digit_command_driver_core_tb;

  localparam int unsigned FRAME_TICKS  = lcdd_pkg::FrameTicksDefault;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned REPORT_CAP   = 100;

  typedef struct packed {
    logic seg_a;
    logic seg_b;
    logic seg_c;
    logic seg_d;
    logic seg_e;
    logic seg_f;
    logic seg_g;
    logic seg_point;
    logic backplane;
  } lcd_pins_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = 1'b0;
  logic [7:0] cmd_byte_i  = 8'd0;
  logic [7:0] arg_byte_i  = 8'd0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       seg_a_o, seg_b_o, seg_c_o, seg_d_o, seg_e_o, seg_f_o, seg_g_o;
  logic       seg_point_o;
  logic       backplane_o;

  lcd_digit_command_driver_core #(
    .FRAME_TICKS(FRAME_TICKS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .cmd_byte_i (cmd_byte_i),
    .arg_byte_i (arg_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .seg_a_o    (seg_a_o),
    .seg_b_o    (seg_b_o),
    .seg_c_o    (seg_c_o),
    .seg_d_o    (seg_d_o),
    .seg_e_o    (seg_e_o),
    .seg_f_o    (seg_f_o),
    .seg_g_o    (seg_g_o),
    .seg_point_o(seg_point_o),
    .backplane_o(backplane_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Display model state
  logic [7:0]                     shown_code  = lcdd_pkg::CodeBlank;
  logic                           dp_on       = 1'b0;
  logic                           blinking    = 1'b0;
  logic [lcdd_pkg::PeriodW-1:0]   blink_len   = lcdd_pkg::BlinkPeriodReset;
  logic [lcdd_pkg::ElapsedW-1:0]  blink_count = '0;
  logic [lcdd_pkg::FrameCntW-1:0] frame_count = '0;
  logic                           bp_level    = 1'b0;
  logic [7:0]                     pin_levels  = 8'h00;

  lcd_pins_t   pins_due[$];
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;

  // Idling controls
  bit          tx_gaps        = 1'b1;
  bit          rx_stalls      = 1'b1;
  int unsigned burst_left     = 0;
  int unsigned rx_hold_cycles = 0;

  function automatic bit char_pattern(input logic [7:0] code, output logic [6:0] segs);
    char_pattern = 1'b1;
    segs = 7'h00;
    case (code)
      8'd48: segs = 7'h3F;  8'd49: segs = 7'h06;  8'd50: segs = 7'h5B;
      8'd51: segs = 7'h4F;  8'd52: segs = 7'h66;  8'd53: segs = 7'h6D;
      8'd54: segs = 7'h7D;  8'd55: segs = 7'h07;  8'd56: segs = 7'h7F;
      8'd57: segs = 7'h6F;  8'd45: segs = 7'h40;  8'd20: segs = 7'h63;
      8'd65: segs = 7'h77;  8'd98: segs = 7'h7C;  8'd99: segs = 7'h58;
      8'd67: segs = 7'h39;  8'd100: segs = 7'h5E; 8'd69: segs = 7'h79;
      8'd70: segs = 7'h71;  8'd72: segs = 7'h76;  8'd73: segs = 7'h30;
      8'd76: segs = 7'h38;  8'd79: segs = 7'h3F;  8'd80: segs = 7'h73;
      8'd83: segs = 7'h6D;  8'd85: segs = 7'h3E;  8'd117: segs = 7'h1C;
      8'd27: segs = 7'h01;  8'd28: segs = 7'h02;  8'd29: segs = 7'h04;
      8'd30: segs = 7'h08;  8'd31: segs = 7'h10;  8'd40: segs = 7'h20;
      8'd33: segs = 7'h40;
      default: char_pattern = 1'b0;
    endcase
  endfunction

  function automatic logic [lcdd_pkg::PeriodW-1:0] blink_len_for(input logic [2:0] idx);
    case (idx)
      3'd0:    blink_len_for = 11'd100;
      3'd1:    blink_len_for = 11'd200;
      3'd2:    blink_len_for = 11'd300;
      3'd3:    blink_len_for = 11'd400;
      3'd4:    blink_len_for = 11'd500;
      3'd5:    blink_len_for = 11'd1000;
      3'd6:    blink_len_for = 11'd1500;
      default: blink_len_for = 11'd2000;
    endcase
  endfunction

  function automatic void redraw_pins();
    logic [6:0] segs;
    logic [7:0] lit;
    bit         drawable;
    drawable = 1'b1;
    lit      = 8'h00;
    if (shown_code == lcdd_pkg::CodeSpace) begin
      lit = 8'h00;
    end else if (shown_code == lcdd_pkg::CodePoint) begin
      dp_on = 1'b1;
      lit   = 8'h80;
    end else if (shown_code == lcdd_pkg::CodeBlank) begin
      lit = {dp_on, 7'h00};
    end else if (char_pattern(shown_code, segs)) begin
      lit = {dp_on, segs};
    end else begin
      // unknown code: hold the segment and point pins
      drawable = 1'b0;
    end
    if (drawable) pin_levels = bp_level ? ~lit : lit;
  endfunction

  function automatic lcd_pins_t predict_pins(input logic op, input logic [7:0] cmd,
                                             input logic [7:0] arg);
    if (op) begin
      if (blink_count != '1) blink_count++;
      if (blinking && (blink_count >= blink_len)) begin
        blink_count = '0;
        dp_on       = ~dp_on;
      end
      if (frame_count != '1) frame_count++;
      if (frame_count >= FRAME_TICKS) begin
        frame_count = '0;
        bp_level    = ~bp_level;
        redraw_pins();
      end
    end else if (cmd == lcdd_pkg::CmdBlinkStart) begin
      if (shown_code == lcdd_pkg::CodeAltBlank) shown_code = lcdd_pkg::CodeBlank;
      blinking = 1'b1;
      if (arg < 8) blink_len = blink_len_for(arg[2:0]);
    end else if (cmd == lcdd_pkg::CmdBlinkStop) begin
      blinking = 1'b0;
      if (arg == 8'd0) dp_on = 1'b0;
      else if (arg == 8'd1) dp_on = 1'b1;
    end else if (cmd == lcdd_pkg::CmdLightA || cmd == lcdd_pkg::CmdLightB ||
                 cmd == lcdd_pkg::CmdLightC) begin
      // backlight control has no effect on the pins
    end else if (cmd == lcdd_pkg::CmdClear) begin
      blinking   = 1'b0;
      dp_on      = 1'b0;
      shown_code = lcdd_pkg::CodeBlank;
    end else begin
      shown_code = cmd;
      if (!blinking) dp_on = (arg != 8'd0);
    end
    return '{pin_levels[0], pin_levels[1], pin_levels[2], pin_levels[3], pin_levels[4],
             pin_levels[5], pin_levels[6], pin_levels[7], bp_level};
  endfunction

  task automatic check_pin(input string name, input logic want, input logic got);
    if (got !== want) begin
      if (errors < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      errors++;
    end
  endtask

  // Score each output transfer against the oldest prediction, then predict
  // the input transfer taken at the same edge.
  always @(posedge clk_i) begin : pin_scoreboard
    lcd_pins_t seen, due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = '{seg_a_o, seg_b_o, seg_c_o, seg_d_o, seg_e_o, seg_f_o, seg_g_o,
                 seg_point_o, backplane_o};
        if (pins_due.size() == 0) begin
          if (errors < REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual %b", $time, seen);
          errors++;
        end else begin
          due = pins_due.pop_front();
          check_pin("seg_a", due.seg_a, seen.seg_a);
          check_pin("seg_b", due.seg_b, seen.seg_b);
          check_pin("seg_c", due.seg_c, seen.seg_c);
          check_pin("seg_d", due.seg_d, seen.seg_d);
          check_pin("seg_e", due.seg_e, seen.seg_e);
          check_pin("seg_f", due.seg_f, seen.seg_f);
          check_pin("seg_g", due.seg_g, seen.seg_g);
          check_pin("seg_point", due.seg_point, seen.seg_point);
          check_pin("backplane", due.backplane, seen.backplane);
          results_seen++;
        end
      end
      if (in_valid_i && in_ready_o)
        pins_due.push_back(predict_pins(op_i, cmd_byte_i, arg_byte_i));
    end
  end

  // Receiver: long hold-offs on request, otherwise a rolling random pattern, or always ready when stalls are off.
  initial begin : rx_stall_pattern
    logic [15:0] pattern;
    int unsigned pos;
    pattern = 16'hFFFF;
    pos     = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (!rx_stalls) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= pattern[pos];
        pos = (pos + 1) % 16;
        if (pos == 0) pattern = 16'($urandom) | 16'($urandom);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer; gaps fall between bursts.
  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [7:0] arg);
    if (tx_gaps && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    cmd_byte_i <= cmd;
    arg_byte_i <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    items_accepted++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(1'b1, 8'($urandom), 8'($urandom));
  endtask

  // Command followed by one full frame so that the redraw shows it.
  task automatic show_command(input logic [7:0] cmd, input logic [7:0] arg);
    send_item(1'b0, cmd, arg);
    send_ticks(FRAME_TICKS);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (results_seen != items_accepted) @(posedge clk_i);
  endtask

  task automatic pick_random_item(output logic op, output logic [7:0] cmd,
                                  output logic [7:0] arg);
    logic [6:0] segs;
    int unsigned sel;
    op  = ($urandom_range(0, 99) < 70);
    arg = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    cmd = 8'($urandom);
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1, 2, 3, 4: begin
        do cmd = 8'($urandom_range(0, 127)); while (!char_pattern(cmd, segs));
      end
      5:  cmd = lcdd_pkg::CodeBlank;
      6:  cmd = lcdd_pkg::CodeAltBlank;
      7:  cmd = lcdd_pkg::CodeSpace;
      8:  cmd = lcdd_pkg::CodePoint;
      9, 10: begin
        cmd = lcdd_pkg::CmdBlinkStart;
        // favor the short periods so the point toggles often
        arg = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      end
      11: begin
        cmd = lcdd_pkg::CmdBlinkStop;
        if ($urandom_range(0, 3) != 0) arg = 8'($urandom_range(0, 2));
      end
      12: cmd = lcdd_pkg::CmdLightA + 8'($urandom_range(0, 2));
      13: cmd = lcdd_pkg::CmdClear;
      default: ;
    endcase
  endtask

  task automatic test_default_blink_period();
    // out-of-range speed keeps the 20-tick period from reset
    send_item(1'b0, lcdd_pkg::CmdBlinkStart, 8'd8);
    send_ticks(45);
    show_command(lcdd_pkg::CmdBlinkStop, 8'd0);
    wait_drained();
  endtask

  task automatic test_characters();
    show_command(8'd48, 8'd0);
    show_command(8'd57, 8'd255);
    show_command(lcdd_pkg::CodeSpace, 8'd1);
    show_command(lcdd_pkg::CodePoint, 8'd0);
    show_command(lcdd_pkg::CodeBlank, 8'd0);
    show_command(lcdd_pkg::CodeBlank, 8'd1);
    show_command(8'd0, 8'd0);
    show_command(8'd255, 8'd1);
    show_command(lcdd_pkg::CmdLightA, 8'd0);
    show_command(lcdd_pkg::CmdLightB, 8'd255);
    show_command(lcdd_pkg::CmdLightC, 8'd1);
    show_command(lcdd_pkg::CodeAltBlank, 8'd1);
    show_command(lcdd_pkg::CmdBlinkStart, 8'd9);
    show_command(8'd20, 8'd0);
    show_command(lcdd_pkg::CmdBlinkStop, 8'd1);
    show_command(lcdd_pkg::CmdBlinkStop, 8'd0);
    show_command(lcdd_pkg::CmdBlinkStop, 8'd2);
    show_command(8'd117, 8'd128);
    show_command(lcdd_pkg::CmdClear, 8'd0);
    wait_drained();
  endtask

  task automatic test_blink_periods();
    // run the short speed steps long enough for the point to toggle
    show_command(8'd48, 8'd0);
    for (int idx = 0; idx < 4; idx++) begin
      send_item(1'b0, lcdd_pkg::CmdBlinkStart, 8'(idx));
      send_ticks(blink_len_for(3'(idx)) + FRAME_TICKS);
    end
    show_command(lcdd_pkg::CmdClear, 8'd0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    logic       op;
    logic [7:0] cmd, arg;
    tx_gaps        = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) begin
      pick_random_item(op, cmd, arg);
      send_item(op, cmd, arg);
    end
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic       op;
    logic [7:0] cmd, arg;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        tx_gaps   = ($urandom_range(0, 3) != 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
      end
      // pause the sender until everything outstanding has come back
      if (n % 400 == 399) wait_drained();
      pick_random_item(op, cmd, arg);
      send_item(op, cmd, arg);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_blink_period();
    test_characters();
    test_blink_periods();
    test_output_backpressure();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pins_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
